@@ design/dtf_pkg.sv @@
`timescale 1ns / 1ps
// dtf_pkg: shared widths, types and constants of the decimal text to fixed point block
// used by dtf_if.sv and decimal_text_to_fixed_point_top.sv; no dependencies

package dtf_pkg;

  localparam int CharW  = 8;
  localparam int ValueW = 32;
  localparam int PrecW  = 4;
  localparam int PowN   = 1 << PrecW;

  typedef logic [CharW-1:0]  char_t;
  typedef logic [ValueW-1:0] word_t;
  typedef logic [PrecW-1:0]  prec_t;

  localparam char_t CharMinus = 8'h2D;
  localparam char_t CharPlus  = 8'h2B;
  localparam char_t CharDot   = 8'h2E;
  localparam char_t CharZero  = 8'h30;
  localparam char_t CharNine  = 8'h39;

  // ten to the k, modulo 2^32
  localparam word_t Pow10 [PowN] = '{
    32'h0000_0001, 32'h0000_000A, 32'h0000_0064, 32'h0000_03E8,
    32'h0000_2710, 32'h0001_86A0, 32'h000F_4240, 32'h0098_9680,
    32'h05F5_E100, 32'h3B9A_CA00, 32'h540B_E400, 32'h4876_E800,
    32'hD4A5_1000, 32'h4E72_A000, 32'h107A_4000, 32'hA4C6_8000
  };

endpackage

@@ design/dtf_if.sv @@
`timescale 1ns / 1ps
// dtf_in_if / dtf_out_if: valid/ready channels for characters and results
// depends on dtf_pkg

interface dtf_in_if import dtf_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t char_in;
  logic  last;

  modport source (output valid, output char_in, output last, input ready);
  modport sink   (input valid, input char_in, input last, output ready);
endinterface

interface dtf_out_if import dtf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

@@ design/decimal_text_to_fixed_point_top.sv @@
`timescale 1ns / 1ps
// decimal_text_to_fixed_point_top: parses a decimal token one character a request
// depends on dtf_pkg and the channel interfaces in dtf_if.sv
//
// usage:
//   in_ch carries one ASCII character per request, last marks the end of a token.
//   Characters that are not last produce no result; the last one produces one
//   result on out_ch: value is the number scaled by ten to precision (wrapping
//   modulo 2^32), status is 1 for a malformed token (value then 0).
//   cfg_we/cfg_wdata write precision (reset 0); write it between tokens.
//   throughput: one character per cycle, sustained, while out_ch keeps up.
//   path of a result: the parse step and padding factor select for its last
//   character are registered in the multiply stage; the 32x32 multiply that
//   applies padding and sign is registered in the output register.
//   when out_ch stalls, one result waits in the output register and a second
//   in the multiply stage; in_ch.ready drops only when both are full.
//   reset (rst_n low, synchronous) clears the token state, precision and
//   both pipeline stages; no result is pending afterwards.

module decimal_text_to_fixed_point_top import dtf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  dtf_in_if.sink     in_ch,
  dtf_out_if.source  out_ch,
  input  logic       cfg_we,
  input  prec_t      cfg_wdata
);

  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_SIGN  = 3'd1;
  localparam logic [2:0] PH_INT   = 3'd2;
  localparam logic [2:0] PH_DOT   = 3'd3;
  localparam logic [2:0] PH_FRAC  = 3'd4;
  localparam logic [2:0] PH_BAD   = 3'd5;

  // token state
  logic [2:0] phase_r, phase_nxt;
  logic       neg_r, neg_nxt;
  word_t      acc_r, acc_nxt;
  prec_t      frac_cnt_r, frac_cnt_nxt;
  prec_t      prec_r;

  // multiply stage and output register
  logic  s1_valid_r, s1_valid_nxt;
  word_t s1_acc_r, s1_factor_r;
  logic  s1_bad_r;
  logic  out_valid_r, out_valid_nxt;
  word_t out_value_r;
  logic  out_status_r;

  logic  take, out_free, s1_move, is_digit, tok_ok;
  word_t acc_step, digit_w, factor, product;
  prec_t pad_exp;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_move     = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign take        = in_ch.valid && in_ch.ready;

  assign is_digit = (in_ch.char_in >= CharZero) && (in_ch.char_in <= CharNine);
  assign digit_w  = {{(ValueW - CharW){1'b0}}, in_ch.char_in - CharZero};
  assign acc_step = (acc_r << 3) + (acc_r << 1) + digit_w;

  always_comb begin
    phase_nxt    = phase_r;
    neg_nxt      = neg_r;
    acc_nxt      = acc_r;
    frac_cnt_nxt = frac_cnt_r;
    unique case (phase_r)
      PH_START: begin
        if (in_ch.char_in == CharMinus || in_ch.char_in == CharPlus) begin
          neg_nxt   = (in_ch.char_in == CharMinus);
          phase_nxt = PH_SIGN;
        end else if (is_digit) begin
          acc_nxt   = digit_w;
          phase_nxt = PH_INT;
        end else begin
          phase_nxt = PH_BAD;
        end
      end
      PH_SIGN: begin
        if (is_digit) begin
          acc_nxt   = digit_w;
          phase_nxt = PH_INT;
        end else begin
          phase_nxt = PH_BAD;
        end
      end
      PH_INT: begin
        if (is_digit) begin
          acc_nxt = acc_step;
        end else if (in_ch.char_in == CharDot) begin
          phase_nxt = PH_DOT;
        end else begin
          phase_nxt = PH_BAD;
        end
      end
      PH_DOT, PH_FRAC: begin
        if (is_digit) begin
          // digits past the precision are dropped
          if (frac_cnt_r < prec_r) begin
            acc_nxt      = acc_step;
            frac_cnt_nxt = frac_cnt_r + 1'b1;
          end
          phase_nxt = PH_FRAC;
        end else begin
          phase_nxt = PH_BAD;
        end
      end
      default: phase_nxt = PH_BAD;
    endcase
  end

  // padding exponent and sign folded into one factor; bad tokens multiply by zero
  assign tok_ok  = (phase_nxt == PH_INT) || (phase_nxt == PH_FRAC);
  assign pad_exp = (frac_cnt_nxt < prec_r) ? prec_r - frac_cnt_nxt : '0;
  assign factor  = !tok_ok ? '0 : (neg_nxt ? word_t'(-Pow10[pad_exp]) : Pow10[pad_exp]);

  assign product = s1_acc_r * s1_factor_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (take && in_ch.last) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      neg_r       <= 1'b0;
      acc_r       <= '0;
      frac_cnt_r  <= '0;
      prec_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        prec_r <= cfg_wdata;
      end
      if (take) begin
        if (in_ch.last) begin
          phase_r    <= PH_START;
          neg_r      <= 1'b0;
          acc_r      <= '0;
          frac_cnt_r <= '0;
        end else begin
          phase_r    <= phase_nxt;
          neg_r      <= neg_nxt;
          acc_r      <= acc_nxt;
          frac_cnt_r <= frac_cnt_nxt;
        end
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_ch.last) begin
      s1_acc_r    <= acc_nxt;
      s1_factor_r <= factor;
      s1_bad_r    <= !tok_ok;
    end
    if (s1_move) begin
      out_value_r  <= product;
      out_status_r <= s1_bad_r;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.value  = $signed(out_value_r);
  assign out_ch.status = out_status_r;

`ifndef NO_ASSERTIONS
  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status |-> out_ch.value == 0)
    else $error("malformed token result carries a nonzero value");

  a_token_clears: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_ch.last |=> phase_r == PH_START && acc_r == 0 && frac_cnt_r == 0)
    else $error("token state not cleared after last character");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_free |=> s1_valid_r && $stable(s1_acc_r) && $stable(s1_factor_r))
    else $error("multiply stage overwritten while output stalled");

  a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted with both stages full");
`endif

endmodule
